// ===== rtl/core/zbh_pkg.sv =====
package zbh_pkg;

   typedef logic [63:0] key_type;

   localparam int KEY_COUNT  = 781;
   localparam int PIECE_KEYS = 768;
   localparam int AUX_KEYS   = 13;
   localparam int AUX_SIDE   = 0;
   localparam int AUX_CASTLE = 1;
   localparam int AUX_EP     = 5;

   localparam int MT_N = 312;
   localparam int MT_M = 156;

   localparam key_type MT_SEED   = 64'h0123_4567_89AB_CDEF;
   localparam key_type MT_MULT   = 64'h5851_F42D_4C95_7F2D;
   localparam key_type MT_MAG    = 64'hB502_6F5A_A966_19E9;
   localparam key_type MT_TEMP_A = 64'h5555_5555_5555_5555;
   localparam key_type MT_TEMP_B = 64'h71D6_7FFF_EDA6_0000;
   localparam key_type MT_TEMP_C = 64'hFFF7_EEE0_0000_0000;

   localparam logic [1:0] MODE_CLEAR     = 2'd0;
   localparam logic [1:0] MODE_ADD_PIECE = 2'd1;
   localparam logic [1:0] MODE_ADD_STATE = 2'd2;
   localparam logic [1:0] MODE_MOVE      = 2'd3;

   localparam logic [3:0] PIECE_WPAWN = 4'd0;
   localparam logic [3:0] PIECE_WROOK = 4'd3;
   localparam logic [3:0] PIECE_BPAWN = 4'd6;
   localparam logic [3:0] PIECE_BROOK = 4'd9;
   localparam logic [3:0] NO_PIECE    = 4'd12;

   function automatic key_type mt_temper(input key_type v);
      key_type y;
      y = v;
      y = y ^ ((y >> 29) & MT_TEMP_A);
      y = y ^ ((y << 17) & MT_TEMP_B);
      y = y ^ ((y << 37) & MT_TEMP_C);
      y = y ^ (y >> 43);
      return y;
   endfunction

endpackage

// ===== rtl/core/zobrist_board_hash.sv =====
// Pipeline: a request transfer is registered by the key-read stage, then by the hash
// update stage, which raises rsp_valid. Throughput: one transfer per cycle while
// req_stall is low; the running hash register closes the only loop.
// Reset: synchronous, clears the running hash and the pipeline, then generates the
// key table with an on-chip MT19937-64 sequencer; req_stall is high during that pass.
module zobrist_board_hash
   import zbh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_from_square,
   input  logic [5:0]  req_to_square,
   input  logic [3:0]  req_moving_piece,
   input  logic [3:0]  req_captured_piece,
   input  logic [3:0]  req_promotion_piece,
   input  logic [6:0]  req_ep_square,
   input  logic [3:0]  req_rook_from_col,
   input  logic [2:0]  req_rook_to_col,
   input  logic        req_white_to_move,
   input  logic [3:0]  req_castle_rights,
   input  logic [3:0]  req_ep_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash
);

   localparam logic [3:0] FS_SEED   = 4'd0;
   localparam logic [3:0] FS_MUL0   = 4'd1;
   localparam logic [3:0] FS_MUL1   = 4'd2;
   localparam logic [3:0] FS_MUL2   = 4'd3;
   localparam logic [3:0] FS_MUL3   = 4'd4;
   localparam logic [3:0] FS_ADD    = 4'd5;
   localparam logic [3:0] FS_TSTART = 4'd6;
   localparam logic [3:0] FS_TLOAD  = 4'd7;
   localparam logic [3:0] FS_TREAD  = 4'd8;
   localparam logic [3:0] FS_TCALC  = 4'd9;
   localparam logic [3:0] FS_DONE   = 4'd10;

   // ---------------- key generation ----------------
   logic [3:0] fill_state_ff, fill_state_in;
   logic [8:0] init_idx_ff, init_idx_in;
   logic [8:0] twist_idx_ff, twist_idx_in;
   logic [9:0] key_idx_ff, key_idx_in;
   key_type    x_ff, x_in;
   key_type    prod_ff, prod_in;
   key_type    acc_ff, acc_in;
   key_type    cur_ff, cur_in;
   key_type    st_rd_a_ff, st_rd_b_ff;

   key_type    st_mem [MT_N];
   logic       st_we;
   logic [8:0] st_waddr;
   key_type    st_wdata;
   logic [8:0] st_raddr_a, st_raddr_b;
   logic [8:0] twist_next1, twist_nextm;

   logic [31:0] mul_a, mul_b;
   key_type     mul_prod;
   key_type     init_word, mt_x, twist_word, key_word;
   logic        key_we;
   logic        fill_busy;

   key_type key_a_mem [PIECE_KEYS];
   key_type key_b_mem [PIECE_KEYS];
   key_type key_c_mem [PIECE_KEYS];
   key_type aux_key_ff [AUX_KEYS];
   logic [3:0] aux_widx;

   assign fill_busy = (fill_state_ff != FS_DONE);
   assign mul_prod  = mul_a * mul_b;
   assign init_word = acc_ff + {55'd0, init_idx_ff};
   assign mt_x      = {cur_ff[63:31], st_rd_a_ff[30:0]};
   assign twist_word = st_rd_b_ff ^ (mt_x >> 1) ^ (mt_x[0] ? MT_MAG : '0);
   assign key_word  = mt_temper(twist_word);
   assign aux_widx  = 4'(key_idx_ff - 10'(PIECE_KEYS));

   assign twist_next1 = (twist_idx_ff == 9'(MT_N - 1)) ? '0 : twist_idx_ff + 9'd1;
   assign twist_nextm = (twist_idx_ff >= 9'(MT_N - MT_M)) ? twist_idx_ff - 9'(MT_N - MT_M)
                                                          : twist_idx_ff + 9'(MT_M);
   assign st_raddr_a = (fill_state_ff == FS_TREAD) ? twist_next1 : '0;
   assign st_raddr_b = twist_nextm;

   always_comb begin
      fill_state_in = fill_state_ff;
      init_idx_in   = init_idx_ff;
      twist_idx_in  = twist_idx_ff;
      key_idx_in    = key_idx_ff;
      x_in          = x_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      cur_in        = cur_ff;
      st_we         = 1'b0;
      st_waddr      = twist_idx_ff;
      st_wdata      = twist_word;
      key_we        = 1'b0;
      mul_a         = MT_MULT[31:0];
      mul_b         = x_ff[31:0];
      case (fill_state_ff)
         FS_SEED: begin
            st_we         = 1'b1;
            st_waddr      = '0;
            st_wdata      = MT_SEED;
            x_in          = MT_SEED ^ (MT_SEED >> 62);
            init_idx_in   = 9'd1;
            key_idx_in    = '0;
            fill_state_in = FS_MUL0;
         end
         FS_MUL0: begin
            prod_in       = mul_prod;
            fill_state_in = FS_MUL1;
         end
         FS_MUL1: begin
            mul_b         = x_ff[63:32];
            prod_in       = mul_prod;
            acc_in        = prod_ff;
            fill_state_in = FS_MUL2;
         end
         FS_MUL2: begin
            mul_a         = MT_MULT[63:32];
            prod_in       = mul_prod;
            acc_in        = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
            fill_state_in = FS_MUL3;
         end
         FS_MUL3: begin
            acc_in        = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
            fill_state_in = FS_ADD;
         end
         FS_ADD: begin
            st_we    = 1'b1;
            st_waddr = init_idx_ff;
            st_wdata = init_word;
            x_in     = init_word ^ (init_word >> 62);
            if (init_idx_ff == 9'(MT_N - 1)) begin
               fill_state_in = FS_TSTART;
            end else begin
               init_idx_in   = init_idx_ff + 9'd1;
               fill_state_in = FS_MUL0;
            end
         end
         FS_TSTART: begin
            fill_state_in = FS_TLOAD;
         end
         FS_TLOAD: begin
            cur_in        = st_rd_a_ff;
            twist_idx_in  = '0;
            fill_state_in = FS_TREAD;
         end
         FS_TREAD: begin
            fill_state_in = FS_TCALC;
         end
         FS_TCALC: begin
            st_we      = 1'b1;
            key_we     = 1'b1;
            cur_in     = st_rd_a_ff;
            key_idx_in = key_idx_ff + 10'd1;
            if (key_idx_ff == 10'(KEY_COUNT - 1)) begin
               fill_state_in = FS_DONE;
            end else begin
               twist_idx_in  = twist_next1;
               fill_state_in = FS_TREAD;
            end
         end
         FS_DONE: begin
            fill_state_in = FS_DONE;
         end
         default: begin
            fill_state_in = FS_SEED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_state_ff <= FS_SEED;
         init_idx_ff   <= '0;
         twist_idx_ff  <= '0;
         key_idx_ff    <= '0;
      end else begin
         fill_state_ff <= fill_state_in;
         init_idx_ff   <= init_idx_in;
         twist_idx_ff  <= twist_idx_in;
         key_idx_ff    <= key_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      cur_ff  <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= st_wdata;
      end
      st_rd_a_ff <= st_mem[st_raddr_a];
      st_rd_b_ff <= st_mem[st_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (key_we && (key_idx_ff >= 10'(PIECE_KEYS))) begin
         aux_key_ff[aux_widx] <= key_word;
      end
   end

   // ---------------- request stage: key reads ----------------
   logic       s1_valid_ff, s1_valid_in;
   logic       s2_free, s1_load, req_accept;
   logic [1:0] s1_mode_ff;
   logic       s1_white_ff;
   logic [3:0] s1_rights_ff;
   logic [3:0] s1_ep_file_ff;
   logic       m_from_ff, m_placed_ff, m_capt_ff, m_ep_ff, m_rook_ff;
   key_type    ka0_ff, ka1_ff, kb0_ff, kb1_ff, kc0_ff, kc1_ff;

   logic [3:0] sel_placed, pawn_piece, rook_piece;
   logic [9:0] addr_from, addr_placed, addr_capt, addr_ep, addr_rook0, addr_rook1;

   assign s2_free    = !rsp_valid || !rsp_stall;
   assign req_stall  = fill_busy || (s1_valid_ff && !s2_free);
   assign req_accept = req_valid && !req_stall;
   assign s1_load    = !s1_valid_ff || s2_free;
   assign s1_valid_in = s1_load ? req_accept : s1_valid_ff;

   always_comb begin
      if (req_mode == MODE_ADD_PIECE) begin
         sel_placed = req_moving_piece;
      end else if (req_promotion_piece < NO_PIECE) begin
         sel_placed = req_promotion_piece;
      end else begin
         sel_placed = req_moving_piece;
      end
   end

   assign pawn_piece  = req_white_to_move ? PIECE_BPAWN : PIECE_WPAWN;
   assign rook_piece  = req_white_to_move ? PIECE_WROOK : PIECE_BROOK;
   assign addr_from   = {req_moving_piece, req_from_square};
   assign addr_placed = {sel_placed, req_to_square};
   assign addr_capt   = {req_captured_piece, req_to_square};
   assign addr_ep     = {pawn_piece, req_ep_square[5:0]};
   assign addr_rook0  = {rook_piece, req_from_square[5:3], req_rook_from_col[2:0]};
   assign addr_rook1  = {rook_piece, req_to_square[5:3], req_rook_to_col};

   always_ff @(posedge clock) begin
      if (key_we && (key_idx_ff < 10'(PIECE_KEYS))) begin
         key_a_mem[key_idx_ff] <= key_word;
         key_b_mem[key_idx_ff] <= key_word;
         key_c_mem[key_idx_ff] <= key_word;
      end
      if (req_accept) begin
         ka0_ff <= key_a_mem[addr_from];
         ka1_ff <= key_a_mem[addr_placed];
         kb0_ff <= key_b_mem[addr_capt];
         kb1_ff <= key_b_mem[addr_ep];
         kc0_ff <= key_c_mem[addr_rook0];
         kc1_ff <= key_c_mem[addr_rook1];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff    <= req_mode;
         s1_white_ff   <= req_white_to_move;
         s1_rights_ff  <= req_castle_rights;
         s1_ep_file_ff <= req_ep_file;
         m_from_ff     <= (req_moving_piece < NO_PIECE);
         m_placed_ff   <= (sel_placed < NO_PIECE);
         m_capt_ff     <= (req_captured_piece < NO_PIECE);
         m_ep_ff       <= !req_ep_square[6];
         m_rook_ff     <= !req_rook_from_col[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // ---------------- result stage: hash update ----------------
   key_type    hash_ff, hash_in;
   logic       rsp_valid_ff;
   key_type    piece_mix, castle_mix, ep_mix, side_key;
   logic [3:0] aux_ep_idx;

   assign side_key   = aux_key_ff[AUX_SIDE];
   assign aux_ep_idx = 4'(AUX_EP) + {1'b0, s1_ep_file_ff[2:0]};
   assign ep_mix     = s1_ep_file_ff[3] ? '0 : aux_key_ff[aux_ep_idx];
   assign piece_mix  = (m_from_ff   ? ka0_ff : '0)
                     ^ (m_placed_ff ? ka1_ff : '0)
                     ^ (m_capt_ff   ? kb0_ff : '0)
                     ^ (m_ep_ff     ? kb1_ff : '0)
                     ^ (m_rook_ff   ? (kc0_ff ^ kc1_ff) : '0);

   always_comb begin
      castle_mix = '0;
      for (int b = 0; b < 4; b++) begin
         if (s1_rights_ff[b]) begin
            castle_mix = castle_mix ^ aux_key_ff[AUX_CASTLE + b];
         end
      end
   end

   always_comb begin
      case (s1_mode_ff)
         MODE_CLEAR: begin
            hash_in = '0;
         end
         MODE_ADD_PIECE: begin
            hash_in = hash_ff ^ (m_placed_ff ? ka1_ff : '0);
         end
         MODE_ADD_STATE: begin
            hash_in = hash_ff ^ (s1_white_ff ? '0 : side_key) ^ castle_mix ^ ep_mix;
         end
         default: begin
            hash_in = hash_ff ^ piece_mix ^ side_key;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (s2_free) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            hash_ff <= hash_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = hash_ff;

   // ---------------- assertions ----------------
   a_rsp_from_stage1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result raised without a pending key read");

   a_idle_during_fill: assert property (@(posedge clock) disable iff (reset)
      fill_busy |-> (!s1_valid_ff && !rsp_valid))
      else $error("transfer in flight while key table is being built");

   a_clear_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_free && (s1_mode_ff == MODE_CLEAR)) |=> (rsp_hash == '0))
      else $error("clear did not zero the hash");

   a_key_idx_bound: assert property (@(posedge clock) disable iff (reset)
      key_idx_ff <= 10'(KEY_COUNT))
      else $error("key index past end of table");

endmodule
